/* rtl/fpbr_pkg.sv */
// ----------------------------------------------------------------------------
// fpbr_pkg
// Shared constants, types and helpers of the four-plane bilinear resampler.
// ----------------------------------------------------------------------------
package fpbr_pkg;

  localparam int SensorWidth  = 768;
  localparam int SensorHeight = 494;
  localparam int GreenW       = SensorWidth;
  localparam int RbW          = SensorWidth / 2;
  localparam int PlaneH       = SensorHeight;
  localparam int GreenDepth   = GreenW * PlaneH;
  localparam int RbDepth      = RbW * PlaneH;
  localparam int GAW          = $clog2(GreenDepth);
  localparam int RAW          = $clog2(RbDepth);
  localparam int NumRegs      = 8;
  localparam int PosW         = 14;
  localparam int ColW         = 11;
  localparam int RowW         = 11;

  // reciprocals: ceil(2**shift / divisor), exact over the operand range
  localparam int RecipX       = 167773;
  localparam int RecipXShift  = 22;
  localparam int RecipY       = 289263;
  localparam int RecipYShift  = 23;
  localparam int Recip3       = 5462;
  localparam int Recip3Shift  = 14;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_RENDER = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    PL_RED     = 2'd0,
    PL_GREEN_A = 2'd1,
    PL_GREEN_B = 2'd2,
    PL_BLUE    = 2'd3
  } plane_t;

  typedef struct packed {
    logic [ColW-1:0] x1;
    logic [ColW-1:0] x2;
    logic [RowW-1:0] y1;
    logic [RowW-1:0] y2;
    logic [2:0]      tx;
    logic [2:0]      ty;
  } tap_t;

  // Truncating blend of two 8-bit values with a 3-bit weight
  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                       input logic [2:0] t);
    logic [11:0] s;
    s = 12'(a) * (12'd8 - 12'(t)) + 12'(b) * 12'(t);
    return s[10:3];
  endfunction

endpackage

/* rtl/fpbr_tap_gen.sv */
// ----------------------------------------------------------------------------
// fpbr_tap_gen
// Offset, saturate and clamp one channel position into four tap coordinates.
// ----------------------------------------------------------------------------
module fpbr_tap_gen import fpbr_pkg::*; (
  input  logic [PosW-1:0] bx,
  input  logic [PosW-1:0] by,
  input  logic [11:0]     shift_x,
  input  logic [11:0]     shift_y,
  input  logic            half_x,
  input  logic [ColW-1:0] last_col,
  output tap_t            tap
);
  logic signed [PosW+1:0] px_s, py_s;
  logic [PosW-1:0] px, py, pxh;
  logic [PosW-4:0] ix, iy;

  always_comb begin
    px_s = $signed({2'b0, bx}) + (PosW+2)'($signed(shift_x));
    py_s = $signed({2'b0, by}) + (PosW+2)'($signed(shift_y));
    px   = px_s[PosW+1] ? '0 : px_s[PosW-1:0];
    py   = py_s[PosW+1] ? '0 : py_s[PosW-1:0];
    pxh  = half_x ? (px >> 1) : px;
    ix   = pxh[PosW-1:3];
    iy   = py[PosW-1:3];
    tap.tx = pxh[2:0];
    tap.ty = py[2:0];
    tap.x1 = ((PosW-3)'(last_col) < ix) ? last_col : ColW'(ix);
    tap.x2 = ((PosW-3)'(last_col) < ix + 1'b1) ? last_col : ColW'(ix + 1'b1);
    tap.y1 = ((PosW-3)'(PlaneH-1) < iy) ? RowW'(PlaneH-1) : RowW'(iy);
    tap.y2 = ((PosW-3)'(PlaneH-1) < iy + 1'b1) ? RowW'(PlaneH-1) : RowW'(iy + 1'b1);
  end
endmodule

/* rtl/fpbr_plane.sv */
// ----------------------------------------------------------------------------
// fpbr_plane
// One sample plane: four row/column-parity banks, so two rows of two taps are read
// per cycle; one write and one read per bank each cycle.
// ----------------------------------------------------------------------------
module fpbr_plane import fpbr_pkg::*; #(
  parameter int Width = 768,
  parameter int AW    = 19
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_idx,
  input  logic [7:0]      wr_data,
  input  tap_t            tap,
  output logic [7:0]      d11,
  output logic [7:0]      d21,
  output logic [7:0]      d12,
  output logic [7:0]      d22
);
  localparam int BankD  = ((Width + 1) / 2) * ((PlaneH + 1) / 2);
  localparam int BW     = $clog2(BankD);
  // Width is three times 2**WShift
  localparam int WShift = $clog2(Width) - 2;
  localparam int HiW    = AW - WShift;

  // banks by {row parity, column parity}
  logic [7:0] mem0 [BankD];
  logic [7:0] mem1 [BankD];
  logic [7:0] mem2 [BankD];
  logic [7:0] mem3 [BankD];

  logic [HiW-1:0]  hi;
  logic [HiW+12:0] hq;
  logic [RowW-1:0] wr_next;
  logic [ColW-1:0] wc_next;
  logic [1:0]      wm;
  logic            wen;
  logic [7:0]      wdat;
  logic [ColW-1:0] wc;
  logic [RowW-1:0] wr;
  logic [BW-1:0]   wa;
  logic [1:0]      wb;
  logic [BW-1:0]   a0, a1, a2, a3;
  logic [ColW-1:0] ce, co;
  logic [RowW-1:0] re, ro;
  logic [7:0]      q0, q1, q2, q3;
  logic            sx, sy;
  logic            eqx, eqy;

  always_comb begin
    hi      = wr_idx[AW-1:WShift];
    hq      = (HiW+13)'(hi) * (HiW+13)'(Recip3);
    wr_next = RowW'(hq >> Recip3Shift);
    wm      = 2'(hi - HiW'(wr_next) * HiW'(3));
    wc_next = ColW'({wm, wr_idx[WShift-1:0]});
    wb = {wr[0], wc[0]};
    wa = BW'(32'(wr[RowW-1:1]) * ((Width + 1) / 2) + 32'(wc[ColW-1:1]));
    ce = tap.x1[0] ? tap.x2 : tap.x1;
    co = tap.x1[0] ? tap.x1 : tap.x2;
    re = tap.y1[0] ? tap.y2 : tap.y1;
    ro = tap.y1[0] ? tap.y1 : tap.y2;
    a0 = BW'(32'(re[RowW-1:1]) * ((Width + 1) / 2) + 32'(ce[ColW-1:1]));
    a1 = BW'(32'(re[RowW-1:1]) * ((Width + 1) / 2) + 32'(co[ColW-1:1]));
    a2 = BW'(32'(ro[RowW-1:1]) * ((Width + 1) / 2) + 32'(ce[ColW-1:1]));
    a3 = BW'(32'(ro[RowW-1:1]) * ((Width + 1) / 2) + 32'(co[ColW-1:1]));
  end

  always_ff @(posedge clk) begin
    wen  <= wr_en;
    wr   <= wr_next;
    wc   <= wc_next;
    wdat <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (wen && wb == 2'd0) mem0[wa] <= wdat;
    if (wen && wb == 2'd1) mem1[wa] <= wdat;
    if (wen && wb == 2'd2) mem2[wa] <= wdat;
    if (wen && wb == 2'd3) mem3[wa] <= wdat;
    q0 <= mem0[a0];
    q1 <= mem1[a1];
    q2 <= mem2[a2];
    q3 <= mem3[a3];
    sx <= tap.x1[0];
    sy <= tap.y1[0];
    eqx <= (tap.x1 == tap.x2);
    eqy <= (tap.y1 == tap.y2);
  end

  // on a clamped edge both taps are the same sample
  always_comb begin
    logic [7:0] e1, o1, e2, o2;
    e1 = sy ? q2 : q0;
    o1 = sy ? q3 : q1;
    e2 = eqy ? e1 : (sy ? q0 : q2);
    o2 = eqy ? o1 : (sy ? q1 : q3);
    d11 = sx ? o1 : e1;
    d21 = eqx ? d11 : (sx ? e1 : o1);
    d12 = sx ? o2 : e2;
    d22 = eqx ? d12 : (sx ? e2 : o2);
  end
endmodule

/* rtl/four_plane_bilinear_resampler_unit.sv */
// ----------------------------------------------------------------------------
// four_plane_bilinear_resampler_unit
// Stores four sensor planes and renders bilinearly resampled RGB pixels.
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// command  | start / busy       | command, plane_select, sample_index, ...
// config   | cfg_valid/cfg_ready| cfg_index, cfg_data
// result   | done strobe        | red_out, green_out, blue_out
// One item per cycle while busy is low; renders pass scale, position, tap, bank-read and blend registers before done.
// busy is low outside reset; the plane memories are not cleared by reset.
// The pipeline never stalls: results are strobed once and not held.
module four_plane_bilinear_resampler_unit import fpbr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [1:0]  plane_select,
  input  logic [18:0] sample_index,
  input  logic [7:0]  sample_value,
  input  logic [10:0] pixel_x,
  input  logic [10:0] pixel_y,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output logic        done,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out
);
  logic [11:0] shift_regs [NumRegs];
  logic [5:0]  vld;
  logic        acc;
  logic [PosW+4:0] mx, my;
  logic [PosW+23:0] qx, qy;
  logic [PosW-1:0] bx, by;
  logic [PosW-1:0] bx1, by1;
  tap_t        t_r, t_a, t_b, t_u;
  tap_t        tr, ta, tb, tu;
  tap_t        tr2, ta2, tb2, tu2;
  logic [2:0]  fx [4];
  logic [2:0]  fy [4];
  logic [2:0]  fy2 [4];
  logic        w_r, w_a, w_b, w_u;
  logic [18:0] widx;
  logic [7:0]  wdat;
  logic [7:0]  d [4][4];
  logic [7:0]  top [4];
  logic [7:0]  bot [4];
  logic [7:0]  res [4];
  logic [8:0]  gsum;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) shift_regs[i] <= '0;
    end else if (cfg_valid && cfg_index < 4'(NumRegs)) begin
      shift_regs[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], acc && command == CMD_RENDER};
    end
  end

  // stage 0: scale by 80 and register the writes; the divide by the aspect constants follows
  always_ff @(posedge clk) begin
    mx <= (PosW+5)'(pixel_x) * 19'd80;
    my <= (PosW+5)'(pixel_y) * 19'd80;
    w_r <= acc && command == CMD_WRITE && plane_select == PL_RED
           && sample_index < 19'(RbDepth);
    w_a <= acc && command == CMD_WRITE && plane_select == PL_GREEN_A
           && sample_index < 19'(GreenDepth);
    w_b <= acc && command == CMD_WRITE && plane_select == PL_GREEN_B
           && sample_index < 19'(GreenDepth);
    w_u <= acc && command == CMD_WRITE && plane_select == PL_BLUE
           && sample_index < 19'(RbDepth);
    widx <= sample_index;
    wdat <= sample_value;
  end

  assign qx = (PosW+24)'(mx) * (PosW+24)'(RecipX);
  assign qy = (PosW+24)'(my) * (PosW+24)'(RecipY);
  assign bx = qx[RecipXShift +: PosW] + PosW'(12);
  assign by = qy[RecipYShift +: PosW] + PosW'(2);

  always_ff @(posedge clk) begin
    bx1 <= bx;
    by1 <= by;
  end

  fpbr_tap_gen u_tr (.bx(bx1), .by(by1), .shift_x(shift_regs[0]), .shift_y(shift_regs[1]),
    .half_x(1'b1), .last_col(ColW'(RbW-1)), .tap(t_r));
  fpbr_tap_gen u_ta (.bx(bx1), .by(by1), .shift_x(shift_regs[2]), .shift_y(shift_regs[3]),
    .half_x(1'b0), .last_col(ColW'(GreenW-1)), .tap(t_a));
  fpbr_tap_gen u_tb (.bx(bx1), .by(by1), .shift_x(shift_regs[4]), .shift_y(shift_regs[5]),
    .half_x(1'b0), .last_col(ColW'(GreenW-1)), .tap(t_b));
  fpbr_tap_gen u_tu (.bx(bx1), .by(by1), .shift_x(shift_regs[6]), .shift_y(shift_regs[7]),
    .half_x(1'b1), .last_col(ColW'(RbW-1)), .tap(t_u));

  logic w_r1, w_a1, w_b1, w_u1;
  logic [18:0] widx1;
  logic [7:0]  wdat1;

  // hold writes aligned with the tap stage
  always_ff @(posedge clk) begin
    w_r1 <= w_r; w_a1 <= w_a; w_b1 <= w_b; w_u1 <= w_u;
    widx1 <= widx; wdat1 <= wdat;
    tr <= t_r; ta <= t_a; tb <= t_b; tu <= t_u;
    tr2 <= tr; ta2 <= ta; tb2 <= tb; tu2 <= tu;
  end

  fpbr_plane #(.Width(RbW), .AW(19)) u_pr (.clk(clk), .wr_en(w_r1), .wr_idx(widx1),
    .wr_data(wdat1), .tap(tr), .d11(d[0][0]), .d21(d[0][1]), .d12(d[0][2]), .d22(d[0][3]));
  fpbr_plane #(.Width(GreenW), .AW(19)) u_pa (.clk(clk), .wr_en(w_a1), .wr_idx(widx1),
    .wr_data(wdat1), .tap(ta), .d11(d[1][0]), .d21(d[1][1]), .d12(d[1][2]), .d22(d[1][3]));
  fpbr_plane #(.Width(GreenW), .AW(19)) u_pb (.clk(clk), .wr_en(w_b1), .wr_idx(widx1),
    .wr_data(wdat1), .tap(tb), .d11(d[2][0]), .d21(d[2][1]), .d12(d[2][2]), .d22(d[2][3]));
  fpbr_plane #(.Width(RbW), .AW(19)) u_pu (.clk(clk), .wr_en(w_u1), .wr_idx(widx1),
    .wr_data(wdat1), .tap(tu), .d11(d[3][0]), .d21(d[3][1]), .d12(d[3][2]), .d22(d[3][3]));

  always_comb begin
    fx[0] = tr2.tx; fx[1] = ta2.tx; fx[2] = tb2.tx; fx[3] = tu2.tx;
    fy[0] = tr2.ty; fy[1] = ta2.ty; fy[2] = tb2.ty; fy[3] = tu2.ty;
  end

  // horizontal blend, then vertical blend
  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      top[c] <= blend(d[c][0], d[c][1], fx[c]);
      bot[c] <= blend(d[c][2], d[c][3], fx[c]);
      fy2[c] <= fy[c];
      res[c] <= blend(top[c], bot[c], fy2[c]);
    end
  end

  assign gsum      = 9'(res[1]) + 9'(res[2]);
  assign done      = vld[5];
  assign red_out   = res[0];
  assign green_out = gsum[8:1];
  assign blue_out  = res[3];
endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-plane bilinear resampler testbench
// Fills plane entries on demand so that every render reads written samples
// only, predicts each rendered pixel from a local copy of the planes and the
// channel offsets, and compares every strobed result in order. Offsets are
// swept through zero, both extremes and random settings between phases.
// ----------------------------------------------------------------------------
module testbench import fpbr_pkg::*;;

  localparam int CycleLimit = 600000;
  localparam int RandomItems = 1450;
  localparam int DrainCycles = 10;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        command = 1'b0;
  logic [1:0]  plane_select = '0;
  logic [18:0] sample_index = '0;
  logic [7:0]  sample_value = '0;
  logic [10:0] pixel_x = '0;
  logic [10:0] pixel_y = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;
  logic        done;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;

  logic [7:0]  sample_store [int];
  logic [11:0] offsets [NumRegs];
  pixel_t      pixel_queue [$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          cycles = 0;

  four_plane_bilinear_resampler_unit u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Compare each strobed pixel with the oldest prediction
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && done) begin
      if (pixel_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h %h", red_out, green_out, blue_out);
      end else begin
        want = pixel_queue.pop_front();
        if (want.r !== red_out || want.g !== green_out || want.b !== blue_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected %h %h %h, got %h %h %h",
                     want.r, want.g, want.b, red_out, green_out, blue_out);
        end
      end
    end
  end

  function automatic int plane_width(int pl);
    return (pl == PL_RED || pl == PL_BLUE) ? RbW : GreenW;
  endfunction

  function automatic int plane_depth(int pl);
    return (pl == PL_RED || pl == PL_BLUE) ? RbDepth : GreenDepth;
  endfunction

  function automatic int store_key(int pl, int idx);
    return pl * 524288 + idx;
  endfunction

  // Source position of one channel in eighth-pixel units
  function automatic int channel_pos(int ch, int coord, bit vertical);
    int base;
    int p;
    base = vertical ? coord * 80 / 29 + 2 : coord * 80 / 25 + 12;
    p = base + int'($signed(offsets[ch * 2 + int'(vertical)]));
    if (p < 0) p = 0;
    if (!vertical && (ch == PL_RED || ch == PL_BLUE)) p = p / 2;
    return p;
  endfunction

  function automatic void channel_taps(int ch, int x, int y, output int idx[4],
                                       output int tx, output int ty);
    int w;
    int px;
    int py;
    int x1;
    int x2;
    int y1;
    int y2;
    w = plane_width(ch);
    px = channel_pos(ch, x, 1'b0);
    py = channel_pos(ch, y, 1'b1);
    tx = px % 8;
    ty = py % 8;
    x1 = (px / 8 > w - 1) ? w - 1 : px / 8;
    x2 = (px / 8 + 1 > w - 1) ? w - 1 : px / 8 + 1;
    y1 = (py / 8 > PlaneH - 1) ? PlaneH - 1 : py / 8;
    y2 = (py / 8 + 1 > PlaneH - 1) ? PlaneH - 1 : py / 8 + 1;
    idx[0] = x1 + y1 * w;
    idx[1] = x2 + y1 * w;
    idx[2] = x1 + y2 * w;
    idx[3] = x2 + y2 * w;
  endfunction

  function automatic int channel_value(int ch, int x, int y);
    int idx[4];
    int d[4];
    int tx;
    int ty;
    int top;
    int bot;
    channel_taps(ch, x, y, idx, tx, ty);
    for (int i = 0; i < 4; i++) d[i] = int'(sample_store[store_key(ch, idx[i])]);
    top = (d[0] * (8 - tx) + d[1] * tx) / 8;
    bot = (d[2] * (8 - tx) + d[3] * tx) / 8;
    return ((top * (8 - ty) + bot * ty) / 8) & 255;
  endfunction

  task automatic send_item(cmd_t cmd, plane_t pl, int idx, int val, int x, int y);
    pixel_t p;
    repeat ($urandom_range(0, 3)) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    command = cmd;
    plane_select = pl;
    sample_index = idx[18:0];
    sample_value = val[7:0];
    pixel_x = x[10:0];
    pixel_y = y[10:0];
    do @(posedge clk); while (busy);
    items_sent++;
    if (cmd == CMD_WRITE) begin
      if (idx < plane_depth(pl)) sample_store[store_key(pl, idx)] = val[7:0];
    end else begin
      p.r = 8'(channel_value(PL_RED, x, y));
      p.g = 8'((channel_value(PL_GREEN_A, x, y) + channel_value(PL_GREEN_B, x, y)) / 2);
      p.b = 8'(channel_value(PL_BLUE, x, y));
      pixel_queue.push_back(p);
    end
  endtask

  // Hold off until every pixel is back and the pipeline has emptied
  task automatic drain;
    @(negedge clk);
    start = 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_offset(int idx, int val);
    repeat ($urandom_range(0, 3)) @(negedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx[3:0];
    cfg_data = val[11:0];
    do @(posedge clk); while (!cfg_ready);
    if (idx < NumRegs) offsets[idx] = val[11:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_all_offsets(int val, bit random_vals);
    drain();
    for (int i = 0; i < NumRegs; i++)
      write_offset(i, random_vals ? int'($urandom_range(0, 4095)) : val);
    write_offset($urandom_range(NumRegs, 15), $urandom_range(0, 4095));
  endtask

  // Render a pixel after writing any of its taps that are still unwritten
  task automatic render(int x, int y, int lo, int hi);
    int idx[4];
    int tx;
    int ty;
    for (int ch = 0; ch < 4; ch++) begin
      channel_taps(ch, x, y, idx, tx, ty);
      for (int i = 0; i < 4; i++)
        if (!sample_store.exists(store_key(ch, idx[i])))
          send_item(CMD_WRITE, plane_t'(ch), idx[i], $urandom_range(lo, hi),
                    $urandom_range(0, 2047), $urandom_range(0, 2047));
    end
    send_item(CMD_RENDER, plane_t'($urandom_range(0, 3)), $urandom_range(0, 524287),
              $urandom_range(0, 255), x, y);
  endtask

  task automatic test_directed;
    send_item(CMD_WRITE, PL_RED, RbDepth, 8'hff, 0, 0);
    send_item(CMD_WRITE, PL_BLUE, 524287, 8'hff, 2047, 2047);
    send_item(CMD_WRITE, PL_GREEN_A, GreenDepth, 8'h00, 0, 0);
    send_item(CMD_WRITE, PL_GREEN_B, 524287, 8'hff, 0, 0);
    render(0, 0, 255, 255);
    render(1, 1, 0, 0);
    render(1899, 1420, 0, 255);
    render(2047, 2047, 0, 255);
    render(2047, 0, 0, 255);
    render(0, 2047, 0, 255);
    render(957, 611, 0, 255);
  endtask

  task automatic test_random_phase(int count);
    int wx;
    int wy;
    int goal;
    goal = items_sent + count;
    wx = $urandom_range(0, 2047);
    wy = $urandom_range(0, 2047);
    while (items_sent < goal) begin
      if ($urandom_range(0, 29) == 0) begin
        wx = $urandom_range(0, 2047);
        wy = $urandom_range(0, 2047);
      end
      case ($urandom_range(0, 9))
        0: send_item(CMD_WRITE, plane_t'($urandom_range(0, 3)), $urandom_range(0, 524287),
                     $urandom_range(0, 255), $urandom_range(0, 2047), $urandom_range(0, 2047));
        1: render($urandom_range(0, 2047), $urandom_range(0, 2047), 0, 255);
        default: render((wx + $urandom_range(0, 15)) % 2048,
                        (wy + $urandom_range(0, 15)) % 2048, 0, 255);
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < NumRegs; i++) offsets[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    set_all_offsets(2047, 1'b0);
    test_random_phase(RandomItems / 6);
    set_all_offsets(-2048, 1'b0);
    test_random_phase(RandomItems / 6);
    set_all_offsets(0, 1'b1);
    test_random_phase(RandomItems / 6);
    set_all_offsets(0, 1'b1);
    test_random_phase(RandomItems / 6);
    set_all_offsets(0, 1'b0);
    test_random_phase(RandomItems / 3);
    drain();
    if (mismatches == 0 && pixel_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/fpbr_pkg.sv
rtl/fpbr_tap_gen.sv
rtl/fpbr_plane.sv
rtl/four_plane_bilinear_resampler_unit.sv
verif/testbench.sv
